### design/erpv_pkg.sv
package erpv_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int FRAC_BITS_DEF = 8;
  localparam int TRIG_BITS_DEF = 16;
  localparam int ANG_W         = 16;
  localparam int SCR_W         = 16;
  localparam int CFG_W         = COORD_WIDTH;
  localparam int IDX_W         = 3;

  localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ANGLE_Z,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z,
    REG_CENTRE_COL,
    REG_CENTRE_ROW
  } cfg_reg_t;

  // sequencer steps of the sine units and the matrix settle
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SQUARE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_HORNER_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_HORNER_LAST = 4'd5;
  localparam logic [STEP_W-1:0] STEP_FINAL = 4'd6;
  localparam logic [STEP_W-1:0] POLY_TOP = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DONE = 4'd10;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] vz;
  } in_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic                    clipped;
  } out_t;

  // odd Taylor coefficients of sine in Q30, lowest order first
  function automatic logic [30:0] poly_coef(input logic [2:0] k);
    logic [30:0] c;
    case (k)
      3'd0:    c = 31'd1686629713;
      3'd1:    c = 31'd693598669;
      3'd2:    c = 31'd85569306;
      3'd3:    c = 31'd5026995;
      3'd4:    c = 31'd172273;
      3'd5:    c = 31'd3864;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### design/erpv_sine.sv
module erpv_sine import erpv_pkg::*; #(
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                   clk,
  input  logic [ANG_W-1:0]       angle,
  input  logic [STEP_W-1:0]      step,
  output logic signed [TRIG_BITS:0] sin_val
);

  localparam int TF = TRIG_BITS - 1;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] HALF_LSB = 32'd1 << (29 - TF);

  logic [1:0]  quad;
  logic [30:0] t;
  logic [30:0] t2;
  logic [30:0] s;
  logic [30:0] t_fold;
  logic [30:0] op_a;
  logic [30:0] op_b;
  logic [61:0] prod;
  logic [31:0] ph;
  logic [31:0] vc;
  logic [31:0] vr;
  logic [30:0] s_next;
  logic signed [TRIG_BITS:0] mag;

  always_comb begin
    if (angle[14]) begin
      t_fold = {(15'h4000 - {1'b0, angle[13:0]}), 16'b0};
    end else begin
      t_fold = {1'b0, angle[13:0], 16'b0};
    end
    if (step == STEP_SQUARE) begin
      op_a = t_fold;
      op_b = t_fold;
    end else if (step inside {[STEP_HORNER_FIRST:STEP_HORNER_LAST]}) begin
      op_a = s;
      op_b = t2;
    end else begin
      op_a = s;
      op_b = t;
    end
    prod   = {31'b0, op_a} * {31'b0, op_b};
    ph     = prod[61:30];
    s_next = poly_coef(3'(POLY_TOP - step)) - ph[30:0];
    vc     = (ph > ONE_Q30) ? ONE_Q30 : ph;
    vr     = (vc + HALF_LSB) >> (30 - TF);
    mag    = $signed({1'b0, vr[TF:0]});
  end

  always_ff @(posedge clk) begin
    if (step == STEP_SQUARE) begin
      t    <= t_fold;
      quad <= angle[15:14];
      t2   <= ph[30:0];
      s    <= poly_coef(3'(POLY_TOP));
    end else if (step inside {[STEP_HORNER_FIRST:STEP_HORNER_LAST]}) begin
      s <= s_next;
    end else if (step == STEP_FINAL) begin
      sin_val <= quad[1] ? -mag : mag;
    end
  end

endmodule

### design/erpv_matrix.sv
module erpv_matrix import erpv_pkg::*; #(
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [ANG_W-1:0]          angle_x,
  input  logic [ANG_W-1:0]          angle_y,
  input  logic [ANG_W-1:0]          angle_z,
  output logic                      busy,
  output logic signed [TRIG_BITS:0] mat [9]
);

  localparam int TF  = TRIG_BITS - 1;
  localparam int MTW = TRIG_BITS + 1;
  localparam int PRW = 2 * MTW;
  localparam int MW  = 3 * MTW + 1;
  localparam logic signed [MW-1:0] RND = MW'(1) <<< (2 * TF - 1);

  logic [STEP_W-1:0] cnt;
  logic signed [MTW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [MTW-1:0] sy_p, cz_p, sz_p;
  logic signed [PRW-1:0] cycz, cysz, sxsy, cxsz, cxcz, sxcy, sxsz, cxsy, sxcz, cxcy;
  logic signed [MW-1:0] e [9];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cnt <= STEP_SQUARE;
    end else if (cnt != STEP_DONE) begin
      cnt <= cnt + 4'd1;
    end
  end

  assign busy = (cnt != STEP_DONE);

  erpv_sine #(.TRIG_BITS(TRIG_BITS)) u_sx (
    .clk(clk), .angle(angle_x), .step(cnt), .sin_val(sx));
  erpv_sine #(.TRIG_BITS(TRIG_BITS)) u_cx (
    .clk(clk), .angle(angle_x + QUARTER_TURN), .step(cnt), .sin_val(cx));
  erpv_sine #(.TRIG_BITS(TRIG_BITS)) u_sy (
    .clk(clk), .angle(angle_y), .step(cnt), .sin_val(sy));
  erpv_sine #(.TRIG_BITS(TRIG_BITS)) u_cy (
    .clk(clk), .angle(angle_y + QUARTER_TURN), .step(cnt), .sin_val(cy));
  erpv_sine #(.TRIG_BITS(TRIG_BITS)) u_sz (
    .clk(clk), .angle(angle_z), .step(cnt), .sin_val(sz));
  erpv_sine #(.TRIG_BITS(TRIG_BITS)) u_cz (
    .clk(clk), .angle(angle_z + QUARTER_TURN), .step(cnt), .sin_val(cz));

  always_ff @(posedge clk) begin
    cycz <= PRW'(cy) * PRW'(cz);
    cysz <= PRW'(cy) * PRW'(sz);
    sxsy <= PRW'(sx) * PRW'(sy);
    cxsz <= PRW'(cx) * PRW'(sz);
    cxcz <= PRW'(cx) * PRW'(cz);
    sxcy <= PRW'(sx) * PRW'(cy);
    sxsz <= PRW'(sx) * PRW'(sz);
    cxsy <= PRW'(cx) * PRW'(sy);
    sxcz <= PRW'(sx) * PRW'(cz);
    cxcy <= PRW'(cx) * PRW'(cy);
    sy_p <= sy;
    cz_p <= cz;
    sz_p <= sz;
  end

  always_ff @(posedge clk) begin
    e[0] <= MW'(cycz) <<< TF;
    e[1] <= -(MW'(cysz) <<< TF);
    e[2] <= MW'(sy_p) <<< (2 * TF);
    e[3] <= MW'(sxsy) * MW'(cz_p) + (MW'(cxsz) <<< TF);
    e[4] <= (MW'(cxcz) <<< TF) - MW'(sxsy) * MW'(sz_p);
    e[5] <= -(MW'(sxcy) <<< TF);
    e[6] <= (MW'(sxsz) <<< TF) - MW'(cxsy) * MW'(cz_p);
    e[7] <= MW'(cxsy) * MW'(sz_p) + (MW'(sxcz) <<< TF);
    e[8] <= MW'(cxcy) <<< TF;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      mat[i] <= MTW'((e[i] + RND) >>> (2 * TF));
    end
  end

endmodule

### design/erpv_pipe.sv
module erpv_pipe import erpv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  in_t                           in_data,
  input  logic signed [TRIG_BITS:0]     mat [9],
  input  logic signed [COORD_WIDTH-1:0] shift_x,
  input  logic signed [COORD_WIDTH-1:0] shift_y,
  input  logic signed [COORD_WIDTH-1:0] shift_z,
  input  logic signed [SCR_W-1:0]       centre_col,
  input  logic signed [SCR_W-1:0]       centre_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output out_t                          out_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = TRIG_BITS - 1;
  localparam int MTW = TRIG_BITS + 1;
  localparam int P1W = CW + MTW;
  localparam int AW  = P1W + 2;
  localparam int PW  = CW + 5;
  localparam int NW  = PW + 2 - FRAC_BITS;
  localparam int K   = NW + 2;
  localparam int HW  = PW + 3;
  localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'd4) / 64'd5;
  localparam logic [K-1:0] RECIP = K'(RECIP64);
  localparam logic signed [AW-1:0] RND = AW'(1) <<< (TF - 1);
  localparam logic [PW-1:0] FMASK = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic signed [HW-1:0] SMAX = HW'(32767);
  localparam logic signed [HW-1:0] SMIN = HW'(-32768);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  logic signed [CW-1:0]  vin [3];
  logic signed [CW-1:0]  sh [3];
  logic signed [P1W-1:0] prod1 [9];
  logic signed [AW-1:0]  acc [3];
  logic signed [PW-1:0]  p2 [3];

  logic [PW-1:0]        mag;
  logic [PW+1:0]        m3, m2;
  logic signed [PW-1:0] ty_c, tz_c;
  logic                 neg3;
  logic [NW-1:0]        n3, n2;
  logic signed [PW-1:0] ty3, tz3;

  logic [NW+K-1:0]      pr3, pr2;
  logic                 neg4;
  logic [NW-1:0]        q3, q2;
  logic signed [PW-1:0] ty4, tz4;

  logic signed [HW-1:0] qs3, qs2, h, vt, col, row;
  logic                 clip_col, clip_row;

  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  assign vin[0] = in_data.vx;
  assign vin[1] = in_data.vy;
  assign vin[2] = in_data.vz;
  assign sh[0]  = shift_x;
  assign sh[1]  = shift_y;
  assign sh[2]  = shift_z;

  always_ff @(posedge clk) begin
    if (r1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1[3*i+j] <= P1W'(vin[j]) * P1W'(mat[3*i+j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(prod1[3*i]) + AW'(prod1[3*i+1]) + AW'(prod1[3*i+2]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      for (int i = 0; i < 3; i++) begin
        p2[i] <= PW'(acc[i] >>> TF) + PW'(sh[i]);
      end
    end
  end

  always_comb begin
    mag  = p2[0][PW-1] ? PW'(-p2[0]) : PW'(p2[0]);
    m2   = {1'b0, mag, 1'b0};
    m3   = m2 + {2'b00, mag};
    ty_c = p2[1] >>> FRAC_BITS;
    if (p2[1][PW-1] && ((p2[1] & FMASK) != '0)) ty_c = ty_c + PW'(1);
    tz_c = p2[2] >>> FRAC_BITS;
    if (p2[2][PW-1] && ((p2[2] & FMASK) != '0)) tz_c = tz_c + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      neg3 <= p2[0][PW-1];
      n3   <= NW'(m3 >> FRAC_BITS);
      n2   <= NW'(m2 >> FRAC_BITS);
      ty3  <= ty_c;
      tz3  <= tz_c;
    end
  end

  assign pr3 = (NW+K)'(n3) * (NW+K)'(RECIP);
  assign pr2 = (NW+K)'(n2) * (NW+K)'(RECIP);

  always_ff @(posedge clk) begin
    if (r4) begin
      neg4 <= neg3;
      q3   <= NW'(pr3 >> K);
      q2   <= NW'(pr2 >> K);
      ty4  <= ty3;
      tz4  <= tz3;
    end
  end

  always_comb begin
    qs3 = HW'($signed({1'b0, q3}));
    qs2 = HW'($signed({1'b0, q2}));
    if (neg4) begin
      qs3 = -qs3;
      qs2 = -qs2;
    end
    h   = HW'(ty4) - qs3;
    vt  = HW'(tz4) - qs2;
    col = HW'(centre_col) - h;
    row = HW'(centre_row) - vt;
    clip_col = (col > SMAX) || (col < SMIN);
    clip_row = (row > SMAX) || (row < SMIN);
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      out_data.screen_x <= (col > SMAX) ? SCR_W'(SMAX) :
                           (col < SMIN) ? SCR_W'(SMIN) : SCR_W'(col);
      out_data.screen_y <= (row > SMAX) ? SCR_W'(SMAX) :
                           (row < SMIN) ? SCR_W'(SMIN) : SCR_W'(row);
      out_data.clipped  <= clip_col || clip_row;
    end
  end

  assign out_valid = v5;

endmodule

### design/euler_rotate_project_vertex_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data  (vx, vy, vz)
// out       output     out_valid / out_ready   out_data (screen_x, screen_y, clipped)
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One vertex per cycle while neither a stall nor a matrix settle holds the input.
// The five-stage projection pipeline carries each vertex; stalls hold every stage
// with a transaction in it and let bubbles close up behind a waiting result.
// After reset, and after any angle write, in_ready stays low while the sine
// units step through their polynomial and the rotation matrix settles.
module euler_rotate_project_vertex_unit import erpv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TRIG_BITS = TRIG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [ANG_W-1:0]              angle_x, angle_y, angle_z;
  logic signed [COORD_WIDTH-1:0] shift_x, shift_y, shift_z;
  logic signed [SCR_W-1:0]       centre_col, centre_row;
  logic                          angle_wr;
  logic                          mat_busy;
  logic                          pipe_ready;
  logic signed [TRIG_BITS:0]     mat [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x    <= '0;
      angle_y    <= '0;
      angle_z    <= '0;
      shift_x    <= '0;
      shift_y    <= '0;
      shift_z    <= '0;
      centre_col <= '0;
      centre_row <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_X:    angle_x    <= cfg_data[ANG_W-1:0];
        REG_ANGLE_Y:    angle_y    <= cfg_data[ANG_W-1:0];
        REG_ANGLE_Z:    angle_z    <= cfg_data[ANG_W-1:0];
        REG_SHIFT_X:    shift_x    <= COORD_WIDTH'(cfg_data);
        REG_SHIFT_Y:    shift_y    <= COORD_WIDTH'(cfg_data);
        REG_SHIFT_Z:    shift_z    <= COORD_WIDTH'(cfg_data);
        REG_CENTRE_COL: centre_col <= cfg_data[SCR_W-1:0];
        REG_CENTRE_ROW: centre_row <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign angle_wr = cfg_we && (cfg_reg_t'(cfg_index) inside {REG_ANGLE_X, REG_ANGLE_Y,
                                                            REG_ANGLE_Z});

  erpv_matrix #(.TRIG_BITS(TRIG_BITS)) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .restart (angle_wr),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z),
    .busy    (mat_busy),
    .mat     (mat)
  );

  erpv_pipe #(.FRAC_BITS(FRAC_BITS), .TRIG_BITS(TRIG_BITS)) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid && !mat_busy),
    .in_ready   (pipe_ready),
    .in_data    (in_data),
    .mat        (mat),
    .shift_x    (shift_x),
    .shift_y    (shift_y),
    .shift_z    (shift_z),
    .centre_col (centre_col),
    .centre_row (centre_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign in_ready = pipe_ready && !mat_busy;

  a_angle_write_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
               cfg_index == REG_ANGLE_Z) |=> !in_ready)
    else $error("vertex accepted right after an angle write");

  a_clip_means_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |->
      (out_data.screen_x == 16'sh7fff || out_data.screen_x == -16'sh8000 ||
       out_data.screen_y == 16'sh7fff || out_data.screen_y == -16'sh8000))
    else $error("clipped set with neither coordinate on a rail");

  a_reset_blocks: assert property (@(posedge clk) $fell(rst) |-> !in_ready)
    else $error("vertex accepted before the rotation matrix settled");

endmodule

### tb/erpv_projection_checker.sv
`timescale 1ns / 100ps

module erpv_projection_checker import erpv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_t             out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  localparam int TF = TRIG_BITS_DEF - 1;

  logic [ANG_W-1:0]             angle [3];
  logic signed [COORD_WIDTH-1:0] shift [3];
  logic signed [SCR_W-1:0]      centre_col;
  logic signed [SCR_W-1:0]      centre_row;
  out_t                         screen_q [$];

  function automatic longint trig_sine(input logic [ANG_W-1:0] a);
    bit [63:0] coef [6];
    bit [63:0] t, t2, s, v;
    bit [63:0] r;
    coef[0] = 64'd1686629713;
    coef[1] = 64'd693598669;
    coef[2] = 64'd85569306;
    coef[3] = 64'd5026995;
    coef[4] = 64'd172273;
    coef[5] = 64'd3864;
    r = {50'd0, a[13:0]};
    t = a[14] ? ((64'h4000 - r) << 16) : (r << 16);
    t2 = (t * t) >> 30;
    s = coef[5];
    for (int k = 4; k >= 0; k--)
      s = coef[k] - ((s * t2) >> 30);
    v = (s * t) >> 30;
    if (v > (64'd1 << 30))
      v = 64'd1 << 30;
    v = (v + (64'd1 << (29 - TF))) >> (30 - TF);
    return a[15] ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint round_half_up(input longint x, input int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint scale_trunc(input longint x, input longint mul,
                                         input longint div);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = mag * mul / div;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic out_t project_vertex(input in_t vtx);
    longint sx, cx, sy, cy, sz, cz, one;
    longint m [9];
    longint crd [3];
    longint pos [3];
    longint h, vt, col, row;
    out_t   res;
    sx = trig_sine(angle[0]);
    cx = trig_sine(angle[0] + QUARTER_TURN);
    sy = trig_sine(angle[1]);
    cy = trig_sine(angle[1] + QUARTER_TURN);
    sz = trig_sine(angle[2]);
    cz = trig_sine(angle[2] + QUARTER_TURN);
    one = longint'(1) <<< TF;
    m[0] = cy * cz * one;
    m[1] = -(cy * sz * one);
    m[2] = sy * one * one;
    m[3] = sx * sy * cz + cx * sz * one;
    m[4] = cx * cz * one - sx * sy * sz;
    m[5] = -(sx * cy * one);
    m[6] = sx * sz * one - cx * sy * cz;
    m[7] = cx * sy * sz + sx * cz * one;
    m[8] = cx * cy * one;
    for (int i = 0; i < 9; i++)
      m[i] = round_half_up(m[i], 2 * TF);
    crd[0] = vtx.vx;
    crd[1] = vtx.vy;
    crd[2] = vtx.vz;
    for (int i = 0; i < 3; i++)
      pos[i] = round_half_up(crd[0] * m[3*i] + crd[1] * m[3*i+1] + crd[2] * m[3*i+2], TF)
               + longint'(shift[i]);
    h  = scale_trunc(pos[1], 1, longint'(1) <<< FRAC_BITS_DEF)
         - scale_trunc(pos[0], 3, longint'(5) <<< FRAC_BITS_DEF);
    vt = scale_trunc(pos[2], 1, longint'(1) <<< FRAC_BITS_DEF)
         - scale_trunc(pos[0], 2, longint'(5) <<< FRAC_BITS_DEF);
    col = longint'(centre_col) - h;
    row = longint'(centre_row) - vt;
    res.clipped = 1'b0;
    if (col > 32767) begin
      col = 32767;
      res.clipped = 1'b1;
    end else if (col < -32768) begin
      col = -32768;
      res.clipped = 1'b1;
    end
    if (row > 32767) begin
      row = 32767;
      res.clipped = 1'b1;
    end else if (row < -32768) begin
      row = -32768;
      res.clipped = 1'b1;
    end
    res.screen_x = col[SCR_W-1:0];
    res.screen_y = row[SCR_W-1:0];
    return res;
  endfunction

  assign pending = screen_q.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        angle[i] = '0;
        shift[i] = '0;
      end
      centre_col = '0;
      centre_row = '0;
      errors = 0;
      screen_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (screen_q.size() == 0) begin
          $error("unexpected transaction: %p", out_data);
          errors++;
        end else begin
          want = screen_q.pop_front();
          if (out_data.screen_x !== want.screen_x) begin
            $error("screen_x: expected %0d, got %0d", want.screen_x, out_data.screen_x);
            errors++;
          end
          if (out_data.screen_y !== want.screen_y) begin
            $error("screen_y: expected %0d, got %0d", want.screen_y, out_data.screen_y);
            errors++;
          end
          if (out_data.clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_data.clipped);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        screen_q.push_back(project_vertex(in_data));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ANGLE_X:    angle[0] = cfg_data[ANG_W-1:0];
          REG_ANGLE_Y:    angle[1] = cfg_data[ANG_W-1:0];
          REG_ANGLE_Z:    angle[2] = cfg_data[ANG_W-1:0];
          REG_SHIFT_X:    shift[0] = cfg_data;
          REG_SHIFT_Y:    shift[1] = cfg_data;
          REG_SHIFT_Z:    shift[2] = cfg_data;
          REG_CENTRE_COL: centre_col = cfg_data[SCR_W-1:0];
          REG_CENTRE_ROW: centre_row = cfg_data[SCR_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/euler_rotate_project_vertex_unit_tb.sv
`timescale 1ns / 100ps

module euler_rotate_project_vertex_unit_tb;
  import erpv_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               errors;
  int               pending;
  int               sent = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;

  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG = 5000;

  euler_rotate_project_vertex_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  erpv_projection_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall pattern changes at random times, one long hold-off
  initial begin
    int mode, hold_cnt;
    bit held;
    mode = 0;
    hold_cnt = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1;
        hold_cnt = HOLD_CYCLES;
      end
      if ($urandom_range(0, 63) == 0)
        mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 1) == 0);
          2: out_ready = ($urandom_range(0, 4) != 0);
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_vertex(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                             input logic [CFG_W-1:0] z);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid = 1'b1;
    in_data = '{vx: x, vy: y, vz: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1:    return CFG_W'($urandom);
      2:       return CFG_W'($urandom_range(0, 131071)) - CFG_W'(65536);
      3:       return CFG_W'($urandom_range(0, 4095)) - CFG_W'(2048);
      4:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CFG_W'($urandom_range(0, 1 << 20)) - CFG_W'(1 << 19);
    endcase
  endfunction

  task automatic setup_phase(input int kind);
    logic [CFG_W-1:0] v [8];
    case (kind)
      0: v = '{16'h4000, 16'h8000, 16'hC000, 24'h000100, 24'hFFFF00, 24'h000000,
               16'h0000, 16'h0000};
      1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
               16'h7FFF, 16'h7FFF};
      2: v = '{16'h0001, 16'h0000, 16'h3FFF, 24'h800000, 24'h800000, 24'h800000,
               16'h8000, 16'h8000};
      3: v = '{16'h0000, 16'h0000, 16'h0000, 24'h000000, 24'h000000, 24'h000000,
               16'h0000, 16'h0000};
      default: begin
        for (int i = 0; i < 3; i++)
          v[i] = CFG_W'($urandom_range(0, 65535));
        for (int i = 3; i < 6; i++)
          v[i] = ($urandom_range(0, 2) == 0) ? CFG_W'($urandom)
                 : CFG_W'($urandom_range(0, 1 << 18)) - CFG_W'(1 << 17);
        v[6] = CFG_W'($urandom_range(0, 65535));
        v[7] = CFG_W'($urandom_range(0, 65535));
      end
    endcase
    for (int i = 0; i < 8; i++)
      write_reg(cfg_reg_t'(i), v[i]);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes under reset settings, then under quarter turns
    send_vertex(24'h000000, 24'h000000, 24'h000000);
    send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_vertex(24'h800000, 24'h800000, 24'h800000);
    send_vertex(24'h800000, 24'h7FFFFF, 24'h000000);
    send_vertex(24'h7FFFFF, 24'h800000, 24'h800000);
    send_vertex(24'hFFFFFF, 24'h000001, 24'hFFFFFF);
    send_vertex(24'h0000FF, 24'hFFFF01, 24'h000080);
    send_vertex(24'h000280, 24'hFFFD80, 24'h7FFF00);
    send_vertex(24'h555555, 24'hAAAAAA, 24'h555555);
    send_vertex(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    drain();
    setup_phase(0);
    send_vertex(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_vertex(24'h800000, 24'h7FFFFF, 24'h800000);
    send_vertex(24'h010000, 24'h000000, 24'h000000);
    send_vertex(24'h000000, 24'h010000, 24'hFF0000);
    send_vertex(24'h000000, 24'h000000, 24'h000000);

    for (int ph = 1; ph <= 8; ph++) begin
      drain();
      setup_phase(ph);
      for (int n = 0; n < 240; n++)
        send_vertex(rand_coord(), rand_coord(), rand_coord());
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
design/erpv_pkg.sv
design/erpv_sine.sv
design/erpv_matrix.sv
design/erpv_pipe.sv
design/euler_rotate_project_vertex_unit.sv
tb/erpv_projection_checker.sv
tb/euler_rotate_project_vertex_unit_tb.sv
